// ===== src/scalar_kalman_filter_macros.svh =====
// Assertion macros for the scalar Kalman filter checker.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SKF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/skf_pkg.sv =====
// Shared types and constants of the scalar Kalman filter.
`default_nettype none
package skf_pkg;
	localparam int GAIN_BITS = 16;
	localparam int CNT_W     = 5;
	localparam int IDX_W     = 3;

	typedef logic [IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_TIME_STEP  = 3'd0;
	localparam cfg_idx_t REG_PROC_NOISE = 3'd1;
	localparam cfg_idx_t REG_MEAS_NOISE = 3'd2;
	localparam cfg_idx_t REG_INIT_ANGLE = 3'd3;
	localparam cfg_idx_t REG_INIT_VAR   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED_MUL,
		ST_PRED_ADD,
		ST_DIV,
		ST_UPD_SET,
		ST_UPD_MUL,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== src/scalar_kalman_filter.sv =====
// Scalar Kalman filter top level: bit-serial predict, gain division and update.
// Steps in order: predict multiply, predict add, gain division, update set-up, update multiply, done.
// A new sample is taken only once the last one has left the done state; one gain bit or multiplier bit per cycle.
// Input is taken again while a finished result still waits in the output register.
// Reset (arst_n low, asynchronous): config registers to defaults, estimate, run state and output valid cleared, idle.
`default_nettype none
module scalar_kalman_filter #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// slave stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,  // gyro_rate, accel_angle
	input  wire logic                                s_tlast,  // last_sample
	// master stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        m_tdata,  // angle_est, variance_est
	output logic                                     m_tlast,  // run_end
	// config write port
	input  wire logic                                cfg_we,
	input  wire skf_pkg::cfg_idx_t                   cfg_index,
	input  wire logic [DATA_WIDTH-1:0]               cfg_wdata
);
	import skf_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_BITS);
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [GAIN_BITS:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

	// config registers
	logic [GAIN_BITS-1:0] dt_q;
	logic [W-1:0] q_q, r_q, ia_q, iv_q;

	// filter state
	state_t state_q, state_d;
	logic [W-1:0] angle_q, var_q;
	logic in_run_q;

	// captured sample and intermediate values
	logic [W-1:0] meas_q, xp_q, pp_q;
	logic last_q;

	// two bit-serial multiply lanes: a is signed via neg flag, b unsigned
	logic [W-1:0] mcand_a_q, mcand_b_q;
	logic [GAIN_BITS:0] mplier_a_q, mplier_b_q;
	logic [W:0] acc_a_q, acc_b_q;
	logic neg_a_q;

	// restoring divider for the gain
	logic [W+1:0] rem_q;
	logic [W:0] den_q;
	logic [GAIN_BITS:0] k_q;
	logic [CNT_W-1:0] cnt_q;

	// output register
	logic [W-1:0] out_angle_q, out_var_q;
	logic out_last_q, out_valid_q;

	logic s_xfer, out_free;
	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// ---- combinational datapath ----
	logic [W-1:0] in_rate, in_meas, rate_mag;
	assign in_rate  = s_tdata[W-1:0];
	assign in_meas  = s_tdata[2*W-1:W];
	assign rate_mag = in_rate[W-1] ? (~in_rate + 1'b1) : in_rate;

	// multiply step: add on low bit, halve on all but the last step
	logic [W:0] sum_a, sum_b;
	assign sum_a = acc_a_q + (mplier_a_q[0] ? {1'b0, mcand_a_q} : '0);
	assign sum_b = acc_b_q + (mplier_b_q[0] ? {1'b0, mcand_b_q} : '0);

	// signed product term, then angle plus term saturated to W bits
	logic [W+1:0] term_a, base_a, ang_sum;
	logic [W-1:0] ang_sat;
	assign term_a  = neg_a_q ? (~{1'b0, acc_a_q} + 1'b1) : {1'b0, acc_a_q};
	assign base_a  = (state_q == ST_PRED_ADD) ? {{2{angle_q[W-1]}}, angle_q}
	                                          : {{2{xp_q[W-1]}}, xp_q};
	assign ang_sum = base_a + term_a;
	always_comb begin
		if (ang_sum[W+1:W-1] == 3'b000 || ang_sum[W+1:W-1] == 3'b111) begin
			ang_sat = ang_sum[W-1:0];
		end else begin
			ang_sat = ang_sum[W+1] ? SMIN : SMAX;
		end
	end

	// predicted variance, saturated, and gain denominator
	logic [W:0] pp_sum, den_sum;
	logic [W-1:0] pp_sat;
	assign pp_sum  = {1'b0, var_q} + {1'b0, q_q};
	assign pp_sat  = pp_sum[W] ? '1 : pp_sum[W-1:0];
	assign den_sum = {1'b0, pp_sat} + {1'b0, r_q};

	// divider step
	logic [W+1:0] den_ext, rem_sub, rem_nxt;
	logic div_ge;
	assign den_ext = {1'b0, den_q};
	assign div_ge  = rem_q >= den_ext;
	assign rem_sub = rem_q - den_ext;
	assign rem_nxt = div_ge ? rem_sub : rem_q;

	// innovation magnitude and sign
	logic [W:0] diff, diff_mag;
	assign diff     = {meas_q[W-1], meas_q} - {xp_q[W-1], xp_q};
	assign diff_mag = diff[W] ? (~diff + 1'b1) : diff;

	// ---- state machine ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_xfer) state_d = ST_PRED_MUL;
			ST_PRED_MUL: if (cnt_q == CNT_LAST) state_d = ST_PRED_ADD;
			ST_PRED_ADD: state_d = ST_DIV;
			ST_DIV:      if (cnt_q == CNT_LAST) state_d = ST_UPD_SET;
			ST_UPD_SET:  state_d = ST_UPD_MUL;
			ST_UPD_MUL:  if (cnt_q == CNT_LAST) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q        <= GAIN_BITS'(655);
			q_q         <= W'(66);
			r_q         <= W'(6554);
			ia_q        <= '0;
			iv_q        <= W'(65536);
			angle_q     <= '0;
			var_q       <= '0;
			in_run_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIME_STEP:  dt_q <= cfg_wdata[GAIN_BITS-1:0];
					REG_PROC_NOISE: q_q  <= cfg_wdata;
					REG_MEAS_NOISE: r_q  <= cfg_wdata;
					REG_INIT_ANGLE: ia_q <= cfg_wdata;
					REG_INIT_VAR:   iv_q <= cfg_wdata;
					default: ;
				endcase
			end
			// run start: prior comes from the initial registers
			if (s_xfer && !in_run_q) begin
				angle_q <= ia_q;
				var_q   <= iv_q;
			end
			// a new result replaces the one taken in the same cycle
			if (state_q == ST_DONE && out_free) begin
				angle_q     <= ang_sat;
				var_q       <= acc_b_q[W] ? '1 : acc_b_q[W-1:0];
				in_run_q    <= !last_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_xfer) begin
					meas_q     <= in_meas;
					last_q     <= s_tlast;
					mcand_a_q  <= rate_mag;
					neg_a_q    <= in_rate[W-1];
					mplier_a_q <= {1'b0, dt_q};
					acc_a_q    <= '0;
					cnt_q      <= '0;
				end
			end
			ST_PRED_MUL: begin
				acc_a_q    <= (cnt_q == CNT_LAST) ? sum_a : {1'b0, sum_a[W:1]};
				mplier_a_q <= mplier_a_q >> 1;
				cnt_q      <= cnt_q + 1'b1;
			end
			ST_PRED_ADD: begin
				xp_q  <= ang_sat;
				pp_q  <= pp_sat;
				rem_q <= {2'b00, pp_sat};
				den_q <= den_sum;
				k_q   <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				k_q   <= {k_q[GAIN_BITS-1:0], div_ge && (den_q != '0)};
				rem_q <= {rem_nxt[W:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_UPD_SET: begin
				mcand_a_q  <= diff_mag[W-1:0];
				neg_a_q    <= diff[W];
				mplier_a_q <= k_q;
				mcand_b_q  <= pp_q;
				mplier_b_q <= GAIN_ONE - k_q;
				acc_a_q    <= '0;
				acc_b_q    <= '0;
				cnt_q      <= '0;
			end
			ST_UPD_MUL: begin
				acc_a_q    <= (cnt_q == CNT_LAST) ? sum_a : {1'b0, sum_a[W:1]};
				acc_b_q    <= (cnt_q == CNT_LAST) ? sum_b : {1'b0, sum_b[W:1]};
				mplier_a_q <= mplier_a_q >> 1;
				mplier_b_q <= mplier_b_q >> 1;
				cnt_q      <= cnt_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_angle_q <= ang_sat;
					out_var_q   <= acc_b_q[W] ? '1 : acc_b_q[W-1:0];
					out_last_q  <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;

	// result fields from the low bits up, padding bits zero
	always_comb begin
		m_tdata          = '0;
		m_tdata[W-1:0]   = out_angle_q;
		m_tdata[2*W-1:W] = out_var_q;
	end
endmodule
`default_nettype wire

// ===== src/skf_checker.sv =====
// Port-level assertions for the scalar Kalman filter, bound to the top level.
`default_nettype none
`include "scalar_kalman_filter_macros.svh"
module skf_assertions #(
	parameter int DATA_WIDTH = 32
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	input wire logic                              m_tlast
);
	logic s_xfer;
	assign s_xfer = s_tvalid && s_tready;

	// a sample keeps the block busy for its serial steps
	`SKF_ASSERT_NEXT(a_busy_after_in, s_xfer, !s_tready, "input taken while busy")
	`SKF_ASSERT_NOW(a_busy_two, s_xfer, ##2 !s_tready, "block free too early")
	// a stalled result holds
	`SKF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
endmodule

bind scalar_kalman_filter skf_assertions #(.DATA_WIDTH(DATA_WIDTH)) u_skf_assertions (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

// ===== tb/skf_checker.sv =====
// Checker for the scalar Kalman filter: tracks config, predicts each result and compares.
`default_nettype none
module skf_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [63:0]       s_tdata,   // gyro_rate, accel_angle
	input  wire logic              s_tlast,   // last_sample
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [63:0]       m_tdata,   // angle_estimate, variance_estimate
	input  wire logic              m_tlast,   // run_end
	input  wire logic              cfg_we,
	input  wire skf_pkg::cfg_idx_t cfg_index,
	input  wire logic [31:0]       cfg_wdata,
	output int                     err_cnt,
	output int                     pending
);
	import skf_pkg::*;

	localparam longint S_MAX = 64'sh7FFF_FFFF;
	localparam longint S_MIN = -64'sh8000_0000;
	localparam longint U_MAX = 64'sh FFFF_FFFF;
	localparam longint GAIN_ONE = 64'sd1 << GAIN_BITS;

	typedef struct {
		logic [31:0] angle;
		logic [31:0] variance;
		logic        run_end;
	} estimate_t;

	estimate_t estimate_q[$];

	// filter settings and state
	longint dt_r, q_r, r_r, init_angle_r, init_var_r;
	longint angle_st, var_st;
	bit     in_run;

	function automatic longint clamp_s(longint v);
		return (v > S_MAX) ? S_MAX : (v < S_MIN) ? S_MIN : v;
	endfunction

	function automatic longint clamp_u(longint v);
		return (v > U_MAX) ? U_MAX : v;
	endfunction

	// v * g >> 16, truncated toward zero
	function automatic longint scale_tz(longint v, longint g);
		longint mag;
		longint p;
		mag = (v < 0) ? -v : v;
		p = (mag * g) >>> GAIN_BITS;
		return (v < 0) ? -p : p;
	endfunction

	function automatic estimate_t kalman_step(logic [31:0] rate_bits, logic [31:0] meas_bits,
			logic last);
		longint rate, meas, xp, pp, den, k, diff;
		estimate_t e;
		rate = longint'($signed(rate_bits));
		meas = longint'($signed(meas_bits));
		if (!in_run) begin
			angle_st = init_angle_r;
			var_st   = init_var_r;
		end
		xp   = clamp_s(angle_st + scale_tz(rate, dt_r));
		pp   = clamp_u(var_st + q_r);
		den  = pp + r_r;
		k    = (den == 0) ? 0 : (pp << GAIN_BITS) / den;
		diff = meas - xp;
		angle_st = clamp_s(xp + scale_tz(diff, k));
		var_st   = clamp_u((pp * (GAIN_ONE - k)) >>> GAIN_BITS);
		in_run   = !last;
		e.angle    = angle_st[31:0];
		e.variance = var_st[31:0];
		e.run_end  = last;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			dt_r = 655; q_r = 66; r_r = 6554; init_angle_r = 0; init_var_r = 65536;
			angle_st = 0; var_st = 0; in_run = 0;
			estimate_q.delete();
			err_cnt = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIME_STEP:  dt_r = longint'({48'b0, cfg_wdata[15:0]});
					REG_PROC_NOISE: q_r = longint'({32'b0, cfg_wdata});
					REG_MEAS_NOISE: r_r = longint'({32'b0, cfg_wdata});
					REG_INIT_ANGLE: init_angle_r = longint'($signed(cfg_wdata));
					REG_INIT_VAR:   init_var_r = longint'({32'b0, cfg_wdata});
					default: ;  // unused index, write dropped
				endcase
			end
			if (s_tvalid && s_tready)
				estimate_q.push_back(kalman_step(s_tdata[31:0], s_tdata[63:32], s_tlast));
			if (m_tvalid && m_tready) begin
				if (estimate_q.size() == 0) begin
					$error("result transfer with no estimate pending");
					err_cnt++;
				end else begin
					e = estimate_q.pop_front();
					if (m_tdata[31:0] !== e.angle) begin
						$error("angle_estimate: expected %0d actual %0d",
							$signed(e.angle), $signed(m_tdata[31:0]));
						err_cnt++;
					end
					if (m_tdata[63:32] !== e.variance) begin
						$error("variance_estimate: expected %0d actual %0d",
							e.variance, m_tdata[63:32]);
						err_cnt++;
					end
					if (m_tlast !== e.run_end) begin
						$error("run_end: expected %0b actual %0b", e.run_end, m_tlast);
						err_cnt++;
					end
				end
			end
			pending = estimate_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for the scalar Kalman filter: stimulus, stalls, watchdog and verdict.
`default_nettype none
module tb_top;
	import skf_pkg::*;

	// idle chance per cycle, in percent
	localparam int IDLE_PCT = 31;
	// cycles with no transfer on either side before giving up
	localparam int STALL_LIMIT = 4000;
	localparam cfg_idx_t REG_FIRST_UNUSED = REG_INIT_VAR + 3'd1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;      // gyro_rate [31:0], accel_angle [63:32]
	logic        s_tlast = 1'b0;    // last_sample
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;           // angle_estimate [31:0], variance_estimate [63:32]
	logic        m_tlast;           // run_end
	logic        cfg_we = 1'b0;
	cfg_idx_t    cfg_index = REG_TIME_STEP;
	logic [31:0] cfg_wdata = '0;

	int err_cnt;
	int pending;
	bit calm = 1'b0;        // no idling on either side while set
	int run_left = 0;       // samples left in the current random run
	int stall_cycles = 0;

	scalar_kalman_filter #(.DATA_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	skf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.err_cnt(err_cnt), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stalls at random, never while calm
	always @(posedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog: any transfer on either side resets the count
	initial begin
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// one config write; cfg_we stays high until cfg_close
	task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic cfg_close();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one sample transfer; tvalid held high across back-to-back samples
	task automatic send_sample(logic [31:0] rate, logic [31:0] meas, logic last);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {meas, rate};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// let every outstanding estimate come back before touching config
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	// mix of realistic small values and full-range values
	function automatic logic [31:0] pick_value();
		if ($urandom_range(1))
			return $urandom();
		return 32'($signed($urandom_range(2 * 262144)) - 262144);
	endfunction

	task automatic random_samples(int n, bit end_run);
		logic last;
		for (int i = 0; i < n; i++) begin
			if (run_left == 0)
				run_left = $urandom_range(1, 20);
			run_left--;
			last = (run_left == 0) || (end_run && i == n - 1);
			if (last)
				run_left = 0;
			send_sample(pick_value(), pick_value(), last);
		end
	endtask

	task automatic random_config();
		cfg_write(REG_TIME_STEP, $urandom());
		cfg_write(REG_PROC_NOISE, $urandom_range(1) ? $urandom() : $urandom_range(4096));
		cfg_write(REG_MEAS_NOISE, $urandom_range(1) ? $urandom() : $urandom_range(65536));
		cfg_write(REG_INIT_ANGLE, pick_value());
		cfg_write(REG_INIT_VAR, $urandom());
		// writes past the last register are dropped by the block
		cfg_write(cfg_idx_t'(REG_FIRST_UNUSED + $urandom_range(2)), $urandom());
		cfg_close();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, field extremes, both run flags
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 32'h8000_0000, 1'b1);
		drain();

		// max dt (upper bits ignored), zero noise, zero prior: zero denominator
		cfg_write(REG_TIME_STEP, 32'hFFFF_FFFF);
		cfg_write(REG_PROC_NOISE, 32'h0);
		cfg_write(REG_MEAS_NOISE, 32'h0);
		cfg_write(REG_INIT_ANGLE, 32'h7FFF_FFFF);
		cfg_write(REG_INIT_VAR, 32'h0);
		cfg_close();
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'h0001_0000, 32'h0000_0000, 1'b1);
		drain();

		// zero measurement noise: gain of one, estimate snaps to the measurement
		cfg_write(REG_PROC_NOISE, 32'h0000_0100);
		cfg_write(REG_INIT_VAR, 32'hFFFF_FFFF);
		cfg_write(REG_INIT_ANGLE, 32'h8000_0000);
		cfg_close();
		send_sample(32'h8000_0000, 32'h1234_5678, 1'b0);
		send_sample(32'h0000_8000, 32'hFFFF_0000, 1'b0);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		drain();

		// noise at maximum while the run is still open: initial registers unused until that run ends
		cfg_write(REG_PROC_NOISE, 32'hFFFF_FFFF);
		cfg_write(REG_MEAS_NOISE, 32'hFFFF_FFFF);
		cfg_write(REG_INIT_ANGLE, 32'h0);
		cfg_close();
		send_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 32'h8000_0000, 1'b1);
		send_sample(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
		drain();

		// random phases; some leave a run open across the config change
		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			calm = (ph == 3);
			random_samples(75, $urandom_range(1));
			drain();
		end
		calm = 1'b0;

		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
